>>> rtl/dsdm_pkg.sv
// shared types, constants and the character placement table of the slow-data decoder
`timescale 1ns / 1ps
`default_nettype none

package dsdm_pkg;

  localparam int MSG_CHARS      = 20;
  localparam int FRAMES         = 8;
  localparam int ROW_W          = 3;
  localparam int LANE_W         = 2;
  localparam int IDX_W          = 5;
  localparam int ROW_DATA_W     = 24;
  localparam int CMD_FIFO_DEPTH = 4;

  localparam logic [7:0] SYNC_B0   = 8'h55;
  localparam logic [7:0] SYNC_B1   = 8'h2d;
  localparam logic [7:0] SYNC_B2   = 8'h16;
  localparam logic [7:0] KEY_B0    = 8'h70;
  localparam logic [7:0] KEY_B1    = 8'h4f;
  localparam logic [7:0] KEY_B2    = 8'h93;
  localparam logic [7:0] HDR_BASE  = 8'h30;
  localparam logic [7:0] SYNC_FRAME  = 8'd0;
  localparam logic [7:0] FINAL_FRAME = 8'd8;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MSG_CHARS - 1);

  typedef enum logic [1:0] {
    CMD_IDLE,
    CMD_WRITE,
    CMD_FINAL
  } cmd_kind_e;

  // one row per frame: lane 0 = byte0, lane 1 = byte1, lane 2 = byte2, descrambled
  typedef struct packed {
    cmd_kind_e              kind;
    logic [ROW_W-1:0]       row;
    logic [ROW_DATA_W-1:0]  data;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [LANE_W-1:0] lane;
  } char_loc_t;

  // where message character idx sits: odd frames hold two chars in lanes 1-2,
  // even frames three chars in lanes 0-2
  function automatic char_loc_t char_loc(input logic [IDX_W-1:0] idx);
    char_loc_t loc;
    unique case (idx)
      5'd0:    loc = '{row: 3'd0, lane: 2'd1};
      5'd1:    loc = '{row: 3'd0, lane: 2'd2};
      5'd2:    loc = '{row: 3'd1, lane: 2'd0};
      5'd3:    loc = '{row: 3'd1, lane: 2'd1};
      5'd4:    loc = '{row: 3'd1, lane: 2'd2};
      5'd5:    loc = '{row: 3'd2, lane: 2'd1};
      5'd6:    loc = '{row: 3'd2, lane: 2'd2};
      5'd7:    loc = '{row: 3'd3, lane: 2'd0};
      5'd8:    loc = '{row: 3'd3, lane: 2'd1};
      5'd9:    loc = '{row: 3'd3, lane: 2'd2};
      5'd10:   loc = '{row: 3'd4, lane: 2'd1};
      5'd11:   loc = '{row: 3'd4, lane: 2'd2};
      5'd12:   loc = '{row: 3'd5, lane: 2'd0};
      5'd13:   loc = '{row: 3'd5, lane: 2'd1};
      5'd14:   loc = '{row: 3'd5, lane: 2'd2};
      5'd15:   loc = '{row: 3'd6, lane: 2'd1};
      5'd16:   loc = '{row: 3'd6, lane: 2'd2};
      5'd17:   loc = '{row: 3'd7, lane: 2'd0};
      5'd18:   loc = '{row: 3'd7, lane: 2'd1};
      5'd19:   loc = '{row: 3'd7, lane: 2'd2};
      default: loc = '{row: 3'd0, lane: 2'd0};
    endcase
    return loc;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dsdm_front.sv
// front end: frame acceptance, sync tracking, sequence check and descrambling
`timescale 1ns / 1ps
`default_nettype none

module dsdm_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [7:0]       frame_num_i,
  input  wire logic [7:0]       slow_byte0_i,
  input  wire logic [7:0]       slow_byte1_i,
  input  wire logic [7:0]       slow_byte2_i,
  input  wire logic             fifo_full_i,
  output logic                  cmd_push_o,
  output dsdm_pkg::cmd_t        cmd_o
);
  import dsdm_pkg::*;

  logic       synced_q, synced_d;
  logic [3:0] exp_seq_q, exp_seq_d;
  logic       accept;
  logic       is_sync;
  logic       in_seq;
  logic       hdr_ok;
  logic [7:0] frame_m1;

  assign accept   = push_i && !fifo_full_i;
  assign frame_m1 = frame_num_i - 8'd1;
  assign is_sync  = (frame_num_i == SYNC_FRAME) && (slow_byte0_i == SYNC_B0) &&
                    (slow_byte1_i == SYNC_B1) && (slow_byte2_i == SYNC_B2);
  // expected number stays in 1..8 while synced, so equality covers the range check
  assign in_seq   = synced_q && (frame_num_i == {4'd0, exp_seq_q}) &&
                    (frame_num_i != SYNC_FRAME) && (frame_num_i <= FINAL_FRAME);
  assign hdr_ok   = slow_byte0_i == (HDR_BASE | {6'd0, frame_num_i[2:1]});

  always_comb begin
    synced_d      = synced_q;
    exp_seq_d     = exp_seq_q;
    cmd_o.kind    = CMD_IDLE;
    cmd_o.row     = frame_m1[ROW_W-1:0];
    cmd_o.data    = {slow_byte2_i ^ KEY_B2, slow_byte1_i ^ KEY_B1, slow_byte0_i ^ KEY_B0};
    if (is_sync) begin
      synced_d  = 1'b1;
      exp_seq_d = 4'd1;
    end else if (in_seq) begin
      if (frame_num_i[0]) begin
        // a bad header leaves the frame expected again
        if (hdr_ok) begin
          cmd_o.kind = CMD_WRITE;
          exp_seq_d  = exp_seq_q + 4'd1;
        end
      end else if (frame_num_i == FINAL_FRAME) begin
        cmd_o.kind = CMD_FINAL;
        synced_d   = 1'b0;
        exp_seq_d  = 4'd0;
      end else begin
        cmd_o.kind = CMD_WRITE;
        exp_seq_d  = exp_seq_q + 4'd1;
      end
    end
  end

  // every accepted frame goes back, idle ones still step the burst
  assign cmd_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      synced_q  <= 1'b0;
      exp_seq_q <= 4'd0;
    end else if (accept) begin
      synced_q  <= synced_d;
      exp_seq_q <= exp_seq_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    synced_q |-> (exp_seq_q >= 4'd1) && (exp_seq_q <= 4'd8))
    else $error("expected frame out of range while synced");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !synced_q |-> (exp_seq_q == 4'd0))
    else $error("expected frame set while not synced");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_push_o && cmd_o.kind == CMD_FINAL) |=> !synced_q)
    else $error("still synced after final frame");

endmodule

`default_nettype wire

>>> rtl/dsdm_cmd_fifo.sv
// small show-ahead queue carrying commands from front to back
`timescale 1ns / 1ps
`default_nettype none

module dsdm_cmd_fifo #(
  parameter int DEPTH = dsdm_pkg::CMD_FIFO_DEPTH,
  parameter int WIDTH = dsdm_pkg::CMD_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] din_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      dout_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign valid_o = count_q != '0;
  assign dout_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/dsdm_back.sv
// back end: double-banked message rows, burst sequencing and result register
`timescale 1ns / 1ps
`default_nettype none

module dsdm_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  input  wire dsdm_pkg::cmd_t                cmd_i,
  output logic                               cmd_pop_o,
  input  wire logic                          pop_i,
  output logic                               empty_o,
  output logic [dsdm_pkg::IDX_W-1:0]         char_index_o,
  output logic [7:0]                         char_value_o,
  output logic                               last_char_o
);
  import dsdm_pkg::*;

  localparam int ADDR_W = ROW_W + 1;

  logic [ROW_DATA_W-1:0] store_q [2*FRAMES];
  logic                  wr_bank_q;
  logic                  burst_act_q;
  logic [IDX_W-1:0]      burst_pos_q;
  logic                  out_valid_q;
  logic [IDX_W-1:0]      out_idx_q;
  logic [7:0]            out_val_q;
  logic                  out_last_q;

  logic                  is_final;
  logic                  is_write;
  logic                  emit;
  logic                  emit_bank;
  logic [IDX_W-1:0]      emit_pos;
  char_loc_t             loc;
  logic [ROW_DATA_W-1:0] row_data;
  logic [7:0]            emit_val;
  logic                  out_free;

  assign is_final  = cmd_i.kind == CMD_FINAL;
  assign is_write  = (cmd_i.kind == CMD_WRITE) || is_final;
  assign emit      = cmd_valid_i && (is_final || burst_act_q);
  // a completing message starts from its own bank at index zero
  assign emit_bank = is_final ? wr_bank_q : !wr_bank_q;
  assign emit_pos  = is_final ? '0 : burst_pos_q;
  assign loc       = char_loc(emit_pos);
  assign row_data  = store_q[{emit_bank, loc.row}];
  assign out_free  = !out_valid_q || pop_i;
  assign cmd_pop_o = cmd_valid_i && (!emit || out_free);

  always_comb begin
    case (loc.lane)
      2'd0:    emit_val = row_data[7:0];
      2'd1:    emit_val = row_data[15:8];
      2'd2:    emit_val = row_data[23:16];
      default: emit_val = row_data[7:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && is_write) begin
      store_q[ADDR_W'({wr_bank_q, cmd_i.row})] <= cmd_i.data;
    end
    if (cmd_pop_o && emit) begin
      out_idx_q  <= emit_pos;
      out_val_q  <= emit_val;
      out_last_q <= emit_pos == LAST_IDX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_bank_q   <= 1'b0;
      burst_act_q <= 1'b0;
      burst_pos_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_pop_o) begin
        if (is_final) begin
          wr_bank_q <= !wr_bank_q;
        end
        if (emit) begin
          out_valid_q <= 1'b1;
          if (emit_pos == LAST_IDX) begin
            burst_act_q <= 1'b0;
            burst_pos_q <= '0;
          end else begin
            burst_act_q <= 1'b1;
            burst_pos_q <= emit_pos + IDX_W'(1);
          end
        end
      end
    end
  end

  assign empty_o      = !out_valid_q;
  assign char_index_o = out_idx_q;
  assign char_value_o = out_val_q;
  assign last_char_o  = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_pos_q <= LAST_IDX)
    else $error("burst position past end of message");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !burst_act_q |-> (burst_pos_q == '0))
    else $error("burst position held while no burst");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_idx_q == LAST_IDX))
    else $error("last flag on a character other than the final one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && is_final) |=> (burst_act_q && burst_pos_q == IDX_W'(1)))
    else $error("completed message did not start a burst at index zero");

endmodule

`default_nettype wire

>>> rtl/dstar_slow_data_message_decoder.sv
// slow-data text message decoder: frames reach the ports via command queue and result register
// throughput one frame per cycle unless full; each frame yields at most one character result
// the command queue absorbs stalls on the result side until it fills, then full rises
// message rows are double banked, so a new message fills while the previous burst drains
// asynchronous active-low reset clears sync, sequence, burst and queue state; rows are not cleared
`timescale 1ns / 1ps
`default_nettype none

module dstar_slow_data_message_decoder #(
  parameter int FIFO_DEPTH = dsdm_pkg::CMD_FIFO_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [7:0]            frame_num_i,
  input  wire logic [7:0]            slow_byte0_i,
  input  wire logic [7:0]            slow_byte1_i,
  input  wire logic [7:0]            slow_byte2_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [dsdm_pkg::IDX_W-1:0] char_index_o,
  output logic [7:0]                 char_value_o,
  output logic                       last_char_o
);
  import dsdm_pkg::*;

  logic             fifo_full;
  logic             cmd_push;
  cmd_t             cmd_in;
  logic             cmd_valid;
  logic             cmd_pop;
  logic [CMD_W-1:0] cmd_bits;
  cmd_t             cmd_out;

  assign full    = fifo_full;
  assign cmd_out = cmd_t'(cmd_bits);

  dsdm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .frame_num_i  (frame_num_i),
    .slow_byte0_i (slow_byte0_i),
    .slow_byte1_i (slow_byte1_i),
    .slow_byte2_i (slow_byte2_i),
    .fifo_full_i  (fifo_full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  dsdm_cmd_fifo #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH (CMD_W)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .din_i   (cmd_in),
    .full_o  (fifo_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .dout_o  (cmd_bits)
  );

  dsdm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd_out),
    .cmd_pop_o    (cmd_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .char_index_o (char_index_o),
    .char_value_o (char_value_o),
    .last_char_o  (last_char_o)
  );

endmodule

`default_nettype wire
